[hw/rtl/rgb_color_adjust_defines.svh]
// Assertion macros used by the checker of the color adjust block.
`ifndef RGB_COLOR_ADJUST_DEFINES_SVH
`define RGB_COLOR_ADJUST_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RCA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rgb_color_adjust: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define RCA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rgb_color_adjust: next-cycle check failed");

`endif

[hw/rtl/rca_pkg.sv]
package rca_pkg;

  // Pipeline depth from the input register to the output register.
  localparam int NUM_STAGES = 8;

  // Configuration register indexes.
  localparam logic [2:0] REG_MODE        = 3'd0;
  localparam logic [2:0] REG_BRIGHT      = 3'd1;
  localparam logic [2:0] REG_INPUT_LOW   = 3'd2;
  localparam logic [2:0] REG_INPUT_HIGH  = 3'd3;
  localparam logic [2:0] REG_OUTPUT_LOW  = 3'd4;
  localparam logic [2:0] REG_OUTPUT_HIGH = 3'd5;

  typedef enum logic [1:0] {
    MODE_GRAY,
    MODE_SEPIA,
    MODE_BRIGHT,
    MODE_LEVELS
  } rca_mode_t;

  // Unsigned Q0.12 weights.
  typedef logic [11:0] rca_weight_t;

  localparam rca_weight_t GRAY_W [3] = '{12'd1229, 12'd2417, 12'd451};

  localparam rca_weight_t SEPIA_W [3][3] = '{
    '{12'd1610, 12'd3150, 12'd774},
    '{12'd1430, 12'd2810, 12'd688},
    '{12'd1114, 12'd2187, 12'd537}
  };

  // Partial remainder and the quotient register that the dividend bits
  // shift out of while quotient bits shift in.
  typedef struct packed {
    logic [8:0] rem;
    logic [7:0] quo;
  } rca_div_t;

endpackage

[hw/rtl/rca_div_stage.sv]
module rca_div_stage (
  input  rca_pkg::rca_div_t [2:0] div_in,
  input  logic [8:0]              divisor,
  output rca_pkg::rca_div_t [2:0] div_out
);

  // Two restoring division steps on each of the three channels.
  always_comb begin
    rca_pkg::rca_div_t d;
    logic [9:0] trial;
    d = '0;
    trial = '0;
    for (int k = 0; k < 3; k++) begin
      d = div_in[k];
      for (int s = 0; s < 2; s++) begin
        trial = {d.rem, d.quo[7]};
        if (trial >= {1'b0, divisor}) begin
          trial = trial - {1'b0, divisor};
          d.quo = {d.quo[6:0], 1'b1};
        end else begin
          d.quo = {d.quo[6:0], 1'b0};
        end
        d.rem = trial[8:0];
      end
      div_out[k] = d;
    end
  end

endmodule

[hw/rtl/rgb_color_adjust.sv]
// Channel     | Handshake              | Words
// ------------+------------------------+---------------------------------------
// pixel in    | in_valid / in_stall    | red_in, green_in, blue_in, last_in
// pixel out   | out_valid / out_stall  | red_out, green_out, blue_out, last_out
// config      | cfg_write              | cfg_index, cfg_data
//
// One pixel word is accepted per cycle while in_stall is low. Each result goes
// through the eight register stages (input, products, sums, four division
// stages, output) and leaves the output register.
// Reset (rst, synchronous) clears the stage valid bits and loads the register
// defaults. A stall on the output only holds the stages that are full, so
// empty stages keep filling while a finished word waits.

module rgb_color_adjust (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] red_in,
  input  logic [7:0] green_in,
  input  logic [7:0] blue_in,
  input  logic       last_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] red_out,
  output logic [7:0] green_out,
  output logic [7:0] blue_out,
  output logic       last_out
);

  localparam int LAST_STAGE = rca_pkg::NUM_STAGES - 1;
  localparam logic [20:0] ROUND_HALF = 21'd2048;

  // Configuration registers. The user must change them only while the pipeline
  // is empty; the block does not enforce this. Every stage reads them directly.
  rca_pkg::rca_mode_t mode;
  logic [7:0] brightness_offset;
  logic [7:0] input_low;
  logic [7:0] input_high;
  logic [7:0] output_low;
  logic [7:0] output_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= rca_pkg::MODE_GRAY;
      brightness_offset <= 8'd0;
      input_low         <= 8'd0;
      input_high        <= 8'd255;
      output_low        <= 8'd0;
      output_high       <= 8'd255;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rca_pkg::REG_MODE:        mode <= rca_pkg::rca_mode_t'(cfg_data[1:0]);
        rca_pkg::REG_BRIGHT:      brightness_offset <= cfg_data;
        rca_pkg::REG_INPUT_LOW:   input_low <= cfg_data;
        rca_pkg::REG_INPUT_HIGH:  input_high <= cfg_data;
        rca_pkg::REG_OUTPUT_LOW:  output_low <= cfg_data;
        rca_pkg::REG_OUTPUT_HIGH: output_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage valid bits and the ready chain. A stage may load when it is empty
  // or when the stage after it is loading too, which lets bubbles collapse.
  logic [LAST_STAGE:0] vld;
  logic [LAST_STAGE:0] rdy;

  always_comb begin
    rdy[LAST_STAGE] = !vld[LAST_STAGE] || !out_stall;
    for (int i = LAST_STAGE - 1; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i + 1];
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld[LAST_STAGE];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i <= LAST_STAGE; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i - 1];
        end
      end
    end
  end

  // Stage 0: input register. Channel 0 is red, 1 green, 2 blue.
  logic [2:0][7:0] pix0;
  logic            last0;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      pix0  <= {blue_in, green_in, red_in};
      last0 <= last_in;
    end
  end

  // Stage 1: the nine constant-weight products, the brightness result and
  // the clamped levels offset. Grayscale uses the same three weights for
  // every output channel.
  logic [2:0][2:0][19:0] prod_next;
  logic [2:0][7:0]       bri_next;
  logic [2:0][7:0]       diff_next;

  always_comb begin
    rca_pkg::rca_weight_t w;
    logic signed [9:0]    t;
    logic [7:0]           vc;
    w = '0;
    t = '0;
    vc = '0;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        w = (mode == rca_pkg::MODE_GRAY) ? rca_pkg::GRAY_W[j] : rca_pkg::SEPIA_W[k][j];
        prod_next[k][j] = {8'd0, w} * {12'd0, pix0[j]};
      end
      // The offset is sign extended; the sum runs from -128 to 382.
      t = $signed({2'b00, pix0[k]}) +
          $signed({{2{brightness_offset[7]}}, brightness_offset});
      if (t[9]) begin
        bri_next[k] = 8'd0;
      end else if (t[8]) begin
        bri_next[k] = 8'd255;
      end else begin
        bri_next[k] = t[7:0];
      end
      if (pix0[k] < input_low) begin
        vc = input_low;
      end else if (pix0[k] > input_high) begin
        vc = input_high;
      end else begin
        vc = pix0[k];
      end
      diff_next[k] = vc - input_low;
    end
  end

  logic [2:0][2:0][19:0] prod1;
  logic [2:0][7:0]       bri1;
  logic [2:0][7:0]       diff1;
  logic                  last1;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      prod1 <= prod_next;
      bri1  <= bri_next;
      diff1 <= diff_next;
      last1 <= last0;
    end
  end

  // Stage 2: weighted sums with rounding and saturation, or the brightness
  // result in bright mode, and the levels numerator magnitude. The sign of the
  // output span is a property of the registers alone and is applied at the end.
  logic [7:0]       span;
  logic [2:0][7:0]  res_next;
  logic [2:0][15:0] mag_next;

  assign span = (output_high >= output_low) ? (output_high - output_low)
                                            : (output_low - output_high);

  always_comb begin
    logic [20:0] sum;
    sum = '0;
    for (int k = 0; k < 3; k++) begin
      sum = {1'b0, prod1[k][0]} + {1'b0, prod1[k][1]} + {1'b0, prod1[k][2]} + ROUND_HALF;
      if (mode == rca_pkg::MODE_BRIGHT) begin
        res_next[k] = bri1[k];
      end else if (sum[20]) begin
        res_next[k] = 8'd255;
      end else begin
        res_next[k] = sum[19:12];
      end
      mag_next[k] = {8'd0, diff1[k]} * {8'd0, span};
    end
  end

  logic [2:0][7:0]  res2;
  logic [2:0][15:0] mag2;
  logic             last2;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      res2  <= res_next;
      mag2  <= mag_next;
      last2 <= last1;
    end
  end

  // Stages 3 to 6: rounded division (2 * mag + den) / (2 * den) by eight
  // restoring steps, two per stage. The quotient never exceeds 255, so the
  // dividend bits above the low byte start out as the partial remainder.
  logic [7:0] den;
  logic [8:0] divisor;

  assign den     = input_high - input_low;
  assign divisor = {den, 1'b0};

  rca_pkg::rca_div_t [2:0] div_init;

  always_comb begin
    logic [16:0] num;
    num = '0;
    for (int k = 0; k < 3; k++) begin
      num = {mag2[k], 1'b0} + {9'd0, den};
      div_init[k].rem = num[16:8];
      div_init[k].quo = num[7:0];
    end
  end

  rca_pkg::rca_div_t [2:0] div3_next;
  rca_pkg::rca_div_t [2:0] div4_next;
  rca_pkg::rca_div_t [2:0] div5_next;
  rca_pkg::rca_div_t [2:0] div6_next;
  rca_pkg::rca_div_t [2:0] div3;
  rca_pkg::rca_div_t [2:0] div4;
  rca_pkg::rca_div_t [2:0] div5;
  rca_pkg::rca_div_t [2:0] div6;
  logic [2:0][7:0] res3;
  logic [2:0][7:0] res4;
  logic [2:0][7:0] res5;
  logic [2:0][7:0] res6;
  logic            last3;
  logic            last4;
  logic            last5;
  logic            last6;

  rca_div_stage u_div3 (.div_in(div_init), .divisor(divisor), .div_out(div3_next));
  rca_div_stage u_div4 (.div_in(div3),     .divisor(divisor), .div_out(div4_next));
  rca_div_stage u_div5 (.div_in(div4),     .divisor(divisor), .div_out(div5_next));
  rca_div_stage u_div6 (.div_in(div5),     .divisor(divisor), .div_out(div6_next));

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      div3  <= div3_next;
      res3  <= res2;
      last3 <= last2;
    end
    if (rdy[4]) begin
      div4  <= div4_next;
      res4  <= res3;
      last4 <= last3;
    end
    if (rdy[5]) begin
      div5  <= div5_next;
      res5  <= res4;
      last5 <= last4;
    end
    if (rdy[6]) begin
      div6  <= div6_next;
      res6  <= res5;
      last6 <= last5;
    end
  end

  // Stage 7: final selection. Levels applies the span sign to the rounded
  // quotient; a degenerate input range maps everything to the output white
  // point.
  logic [2:0][7:0] out_next;

  always_comb begin
    logic [8:0] lvl;
    lvl = '0;
    for (int k = 0; k < 3; k++) begin
      if (output_high >= output_low) begin
        lvl = {1'b0, output_low} + {1'b0, div6[k].quo};
      end else begin
        lvl = {1'b0, output_low} - {1'b0, div6[k].quo};
      end
      if (mode != rca_pkg::MODE_LEVELS) begin
        out_next[k] = res6[k];
      end else if (input_high <= input_low) begin
        out_next[k] = output_high;
      end else if (lvl[8]) begin
        // Carry on the add means overflow, borrow on the subtract underflow.
        out_next[k] = (output_high >= output_low) ? 8'd255 : 8'd0;
      end else begin
        out_next[k] = lvl[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[LAST_STAGE]) begin
      red_out   <= out_next[0];
      green_out <= out_next[1];
      blue_out  <= out_next[2];
      last_out  <= last6;
    end
  end

endmodule

[hw/rtl/rca_checker.sv]
`include "rgb_color_adjust_defines.svh"

module rca_checker (
  input logic       clk,
  input logic       rst,
  input logic       cfg_write,
  input logic [2:0] cfg_index,
  input logic [7:0] cfg_data,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] red_out,
  input logic [7:0] green_out,
  input logic [7:0] blue_out,
  input logic       last_out
);

  // Words accepted but not yet delivered, and a copy of the mode register.
  logic [3:0] pending;
  logic [1:0] mode_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= 4'd0;
      mode_seen <= rca_pkg::MODE_GRAY;
    end else begin
      pending <= pending + {3'd0, in_valid && !in_stall} - {3'd0, out_valid && !out_stall};
      if (cfg_write && cfg_index == rca_pkg::REG_MODE) begin
        mode_seen <= cfg_data[1:0];
      end
    end
  end

  `RCA_ASSERT_NOW(a_no_invented_word, clk, rst, out_valid, pending != 4'd0)
  `RCA_ASSERT_NOW(a_depth_bound, clk, rst, 1'b1, pending <= rca_pkg::NUM_STAGES)
  `RCA_ASSERT_NOW(a_gray_equal, clk, rst, out_valid && mode_seen == rca_pkg::MODE_GRAY, red_out == green_out && green_out == blue_out)
  `RCA_ASSERT_NOW(a_empty_after_reset, clk, rst, $past(rst), !out_valid)
  `RCA_ASSERT_NEXT(a_stalled_word_held, clk, rst, out_valid && out_stall, out_valid && $stable({red_out, green_out, blue_out, last_out}))

endmodule

bind rgb_color_adjust rca_checker u_rca_checker (.*);
